// File: rtl/nlp_pkg.sv
// Shared types and constants for the nearest-line search.
// No dependencies; every other file in rtl/ uses this package.
package nlp_pkg;

  localparam int unsigned COEF_W        = 16;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned MAX_LINES_DEF = 1024;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t coef_a;
    coef_t coef_b;
    coef_t coef_c;
    logic  is_last;
  } line_t;

  typedef struct packed {
    coef_t            best_a;
    coef_t            best_b;
    coef_t            best_c;
    logic [IDX_W-1:0] best_index;
  } best_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_X = 1'b0,
    CFG_POINT_Y = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_SQ,
    ST_MUL,
    ST_ADD,
    ST_UPD
  } state_e;

  // Stage load enables from the controller to the datapath
  typedef struct packed {
    logic ld_in;
    logic ld_prod;
    logic ld_sum;
    logic ld_sq;
    logic ld_mul;
    logic ld_add;
    logic commit;
  } cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic emit;      // current line closes the set
    logic out_full;  // output register holds a word that is not taken this cycle
  } stat_t;

endpackage

// File: rtl/nlp_line_if.sv
// Input channel carrying one line word per handshake.
// Depends on nlp_pkg for the payload type.
interface nlp_line_if;
  logic           valid;
  logic           ready;
  nlp_pkg::line_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/nlp_best_if.sv
// Output channel carrying the nearest line of a set.
// Depends on nlp_pkg for the payload type.
interface nlp_best_if;
  logic           valid;
  logic           ready;
  nlp_pkg::best_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/nlp_ctrl.sv
// Sequencer for the nearest-line search: walks each line through the datapath stages.
// Depends on nlp_pkg for the state enum and the command/status structs.
module nlp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nlp_pkg::stat_t stat_i,
  output nlp_pkg::cmd_t  cmd_o
);

  nlp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      nlp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = nlp_pkg::ST_PROD;
        end
      end
      nlp_pkg::ST_PROD: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = nlp_pkg::ST_SUM;
      end
      nlp_pkg::ST_SUM: begin
        cmd_o.ld_sum = 1'b1;
        state_d      = nlp_pkg::ST_SQ;
      end
      nlp_pkg::ST_SQ: begin
        cmd_o.ld_sq = 1'b1;
        state_d     = nlp_pkg::ST_MUL;
      end
      nlp_pkg::ST_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = nlp_pkg::ST_ADD;
      end
      nlp_pkg::ST_ADD: begin
        cmd_o.ld_add = 1'b1;
        state_d      = nlp_pkg::ST_UPD;
      end
      nlp_pkg::ST_UPD: begin
        // hold while the closing word has nowhere to go
        if (!(stat_i.emit && stat_i.out_full)) begin
          cmd_o.commit = 1'b1;
          state_d      = nlp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nlp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/nlp_datapath.sv
// Datapath: query point registers, distance arithmetic, best-line hold and output register.
// Depends on nlp_pkg; driven by the command struct from nlp_ctrl.
module nlp_datapath #(
  parameter int unsigned MAX_LINES = nlp_pkg::MAX_LINES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nlp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nlp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  nlp_pkg::line_t                   line_i,
  input  nlp_pkg::cmd_t                    cmd_i,
  output nlp_pkg::stat_t                   stat_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nlp_pkg::best_t                   out_data_o
);

  localparam int unsigned CNT_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned IDX_W = nlp_pkg::IDX_W;

  // configuration
  nlp_pkg::coef_t px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
    end else if (cfg_we_i) begin
      case (nlp_pkg::cfg_reg_e'(cfg_idx_i))
        nlp_pkg::CFG_POINT_X: px_q <= nlp_pkg::coef_t'(cfg_data_i);
        nlp_pkg::CFG_POINT_Y: py_q <= nlp_pkg::coef_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // stage registers
  nlp_pkg::coef_t     a_q, b_q, c_q;
  logic               last_q;
  logic signed [31:0] p_ax_q, p_by_q, p_aa_q, p_bb_q;
  logic        [31:0] mag_q, norm_q;
  logic        [63:0] magsq_q;
  logic        [63:0] pl_lo_q, pl_hi_q, pr_lo_q, pr_hi_q;
  logic        [95:0] lhs_q, rhs_q;

  // best line so far
  nlp_pkg::coef_t     held_a_q, held_b_q, held_c_q;
  logic        [31:0] held_norm_q;
  logic        [63:0] held_numsq_q;
  logic [CNT_W-1:0]   held_idx_q;
  logic [CNT_W-1:0]   count_q;
  logic               have_best_q;

  logic               out_valid_q;
  nlp_pkg::best_t     out_data_q;

  logic signed [33:0] num;
  logic        [33:0] num_abs;
  logic               take;
  logic               emit;
  nlp_pkg::coef_t     sel_a, sel_b, sel_c;
  logic [CNT_W-1:0]   sel_idx;
  logic [CNT_W+IDX_W-1:0] sel_idx_ext;

  assign num = 34'(p_ax_q) + 34'(p_by_q) + {{10{c_q[15]}}, c_q, 8'h00};
  assign num_abs = num[33] ? 34'(-num) : 34'(num);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      a_q    <= line_i.coef_a;
      b_q    <= line_i.coef_b;
      c_q    <= line_i.coef_c;
      last_q <= line_i.is_last;
    end
    if (cmd_i.ld_prod) begin
      p_ax_q <= 32'(a_q) * 32'(px_q);
      p_by_q <= 32'(b_q) * 32'(py_q);
      p_aa_q <= 32'(a_q) * 32'(a_q);
      p_bb_q <= 32'(b_q) * 32'(b_q);
    end
    if (cmd_i.ld_sum) begin
      mag_q  <= num_abs[31:0];
      norm_q <= $unsigned(p_aa_q) + $unsigned(p_bb_q);
    end
    if (cmd_i.ld_sq) begin
      magsq_q <= 64'(mag_q) * 64'(mag_q);
    end
    // split the 64 x 32 cross products into 32 x 32 halves
    if (cmd_i.ld_mul) begin
      pl_lo_q <= 64'(magsq_q[31:0])       * 64'(held_norm_q);
      pl_hi_q <= 64'(magsq_q[63:32])      * 64'(held_norm_q);
      pr_lo_q <= 64'(held_numsq_q[31:0])  * 64'(norm_q);
      pr_hi_q <= 64'(held_numsq_q[63:32]) * 64'(norm_q);
    end
    if (cmd_i.ld_add) begin
      lhs_q <= {pl_hi_q, 32'h0} + 96'(pl_lo_q);
      rhs_q <= {pr_hi_q, 32'h0} + 96'(pr_lo_q);
    end
  end

  // a degenerate line wins only as the first of its set; a degenerate best loses to any proper line
  assign take = !have_best_q ||
                ((norm_q != 32'h0) && ((held_norm_q == 32'h0) || (lhs_q < rhs_q)));
  assign emit = last_q || (count_q == CNT_W'(MAX_LINES - 1));

  assign sel_a       = take ? a_q : held_a_q;
  assign sel_b       = take ? b_q : held_b_q;
  assign sel_c       = take ? c_q : held_c_q;
  assign sel_idx     = take ? count_q : held_idx_q;
  assign sel_idx_ext = {{IDX_W{1'b0}}, sel_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && take) begin
      held_a_q     <= a_q;
      held_b_q     <= b_q;
      held_c_q     <= c_q;
      held_norm_q  <= norm_q;
      held_numsq_q <= magsq_q;
      held_idx_q   <= count_q;
    end
    if (cmd_i.commit && emit) begin
      out_data_q.best_a     <= sel_a;
      out_data_q.best_b     <= sel_b;
      out_data_q.best_c     <= sel_c;
      out_data_q.best_index <= sel_idx_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      count_q     <= '0;
    end else if (cmd_i.commit) begin
      if (emit) begin
        // clear for the next set
        have_best_q <= 1'b0;
        count_q     <= '0;
      end else begin
        have_best_q <= 1'b1;
        count_q     <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.emit     = emit;
  assign stat_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

// File: rtl/nearest_line_to_point.sv
// Nearest line to a configured point over a stream of lines ax+by+c=0 (Q8.8).
// One line in flight at a time: accept, four-stage multiply chain (products, sum, square,
// cross products), 96-bit add, then compare/update; the closing word is registered at its
// commit and may wait in the output register while the next line is taken.
// Reset (async, active low) zeroes the query point and clears the set; no clearing pass.
module nearest_line_to_point #(
  parameter int unsigned MAX_LINES = nlp_pkg::MAX_LINES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nlp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nlp_line_if.sink                       line_i,
  nlp_best_if.source                     best_o
);

  nlp_pkg::cmd_t  cmd;
  nlp_pkg::stat_t stat;

  nlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (line_i.valid),
    .in_ready_o (line_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nlp_datapath #(
    .MAX_LINES (MAX_LINES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .line_i      (line_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (best_o.valid),
    .out_ready_i (best_o.ready),
    .out_data_o  (best_o.data)
  );

  // a new word appears only from a commit of a closing line
  a_rise_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(best_o.valid) |-> $past(cmd.commit))
    else $error("result word appeared without a commit");

  // never commit a closing line over an untaken word
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && stat.emit) |-> !stat.out_full)
    else $error("closing line committed while output held");

  // one line in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_i.valid && line_i.ready) |=> !line_i.ready)
    else $error("input taken while a line is in flight");

  // after a commit the block is ready for the next line
  a_ready_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> line_i.ready)
    else $error("input not ready after commit");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for nearest_line_to_point: drives line words, predicts the nearest line per set.
// Depends on nlp_pkg, nlp_line_if, nlp_best_if and the nearest_line_to_point RTL.
module tb;

  localparam int LINE_LIMIT     = nlp_pkg::MAX_LINES_DEF;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 130;
  localparam int PHASE_ITEMS    = 40;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [nlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [nlp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  nlp_line_if line_ch ();
  nlp_best_if best_ch ();

  nearest_line_to_point DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .line_i     (line_ch),
    .best_o     (best_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Query point and search state as the block should hold them
  nlp_pkg::coef_t query_x   = '0;
  nlp_pkg::coef_t query_y   = '0;
  nlp_pkg::coef_t near_a    = '0;
  nlp_pkg::coef_t near_b    = '0;
  nlp_pkg::coef_t near_c    = '0;
  logic [63:0]    near_num  = '0;
  logic [31:0]    near_norm = '0;
  int             near_pos  = 0;
  int             set_pos   = 0;
  bit             set_open  = 1'b0;

  nlp_pkg::best_t nearest_q[$];
  int    fail_count    = 0;
  bit    idling_on     = 1'b1;
  bit    hold_request  = 1'b0;
  int    rx_hold_left  = 0;
  int    rx_stall_left = 0;
  int    quiet_cycles  = 0;

  // Fold one accepted line into the search; queue the word a closing line yields
  function automatic void track_nearest(input nlp_pkg::line_t ln);
    longint         num;
    longint         norm;
    logic [63:0]    mag;
    logic [31:0]    norm_u;
    logic [127:0]   lhs;
    logic [127:0]   rhs;
    bit             take;
    nlp_pkg::best_t res;
    num = longint'(ln.coef_a) * longint'(query_x) + longint'(ln.coef_b) * longint'(query_y)
        + longint'(ln.coef_c) * 256;
    norm = longint'(ln.coef_a) * longint'(ln.coef_a) + longint'(ln.coef_b) * longint'(ln.coef_b);
    mag = (num < 0) ? -num : num;
    norm_u = norm[31:0];
    if (!set_open) begin
      take = 1'b1;
    end else if (norm_u == 0) begin
      take = 1'b0;
    end else if (near_norm == 0) begin
      take = 1'b1;
    end else begin
      // cross-multiplied squared distances, exact at 128 bits
      lhs = mag;
      lhs = lhs * lhs * near_norm;
      rhs = near_num;
      rhs = rhs * rhs * norm_u;
      take = lhs < rhs;
    end
    if (take) begin
      near_a    = ln.coef_a;
      near_b    = ln.coef_b;
      near_c    = ln.coef_c;
      near_num  = mag;
      near_norm = norm_u;
      near_pos  = set_pos;
      set_open  = 1'b1;
    end
    if (ln.is_last || set_pos >= LINE_LIMIT - 1) begin
      res.best_a     = near_a;
      res.best_b     = near_b;
      res.best_c     = near_c;
      res.best_index = near_pos[nlp_pkg::IDX_W-1:0];
      nearest_q.push_back(res);
      near_a    = '0;
      near_b    = '0;
      near_c    = '0;
      near_num  = '0;
      near_norm = '0;
      near_pos  = 0;
      set_pos   = 0;
      set_open  = 1'b0;
    end else begin
      set_pos++;
    end
  endfunction

  function automatic nlp_pkg::coef_t pick_coef();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return nlp_pkg::coef_t'(int'($urandom_range(0, 16)) - 8);
      default: return nlp_pkg::coef_t'($urandom);
    endcase
  endfunction

  // Offer one line word, hold it until taken, then predict
  task automatic send_line(input nlp_pkg::coef_t a, input nlp_pkg::coef_t b,
                           input nlp_pkg::coef_t c, input bit last);
    nlp_pkg::line_t ln;
    ln.coef_a  = a;
    ln.coef_b  = b;
    ln.coef_c  = c;
    ln.is_last = last;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      line_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    line_ch.valid <= 1'b1;
    line_ch.data  <= ln;
    do @(posedge clk_i); while (!line_ch.ready);
    track_nearest(ln);
  endtask

  // Drop valid, drain the results, then let any line still in the pipe finish
  task automatic wait_idle();
    @(negedge clk_i);
    line_ch.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input nlp_pkg::cfg_reg_e idx, input nlp_pkg::coef_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == nlp_pkg::CFG_POINT_X) query_x = val;
    else query_y = val;
  endtask

  task automatic set_point(input nlp_pkg::coef_t x, input nlp_pkg::coef_t y);
    wait_idle();
    write_reg(nlp_pkg::CFG_POINT_X, x);
    write_reg(nlp_pkg::CFG_POINT_Y, y);
  endtask

  task automatic test_directed_cases();
    // query point still at its reset value
    send_line(32767, -32768, -32768, 1'b1);
    // degenerate first line gives way; a later degenerate one never wins
    send_line(0, 0, 5, 1'b0);
    send_line(1, 0, 3, 1'b0);
    send_line(0, 0, 0, 1'b1);
    // every line degenerate: first one stands
    send_line(0, 0, -32768, 1'b0);
    send_line(0, 0, 32767, 1'b1);
    // equal distances keep the earlier line
    send_line(3, 4, 10, 1'b0);
    send_line(6, 8, 20, 1'b0);
    send_line(3, 4, 10, 1'b1);
    send_line(256, 0, 100, 1'b0);
    send_line(0, 256, -50, 1'b1);
    set_point(-32768, 32767);
    send_line(-32768, -32768, 32767, 1'b0);
    send_line(32767, 32767, -32768, 1'b0);
    send_line(-32768, 32767, 0, 1'b1);
    set_point(32767, -32768);
    send_line(32767, -32768, 32767, 1'b0);
    send_line(-1, -1, -1, 1'b0);
    send_line(1, 1, 1, 1'b1);
    wait_idle();
  endtask

  // A long run of lines with no last mark: the set must close on its own at the line limit
  task automatic test_overlong_set();
    int             i;
    int             span;
    nlp_pkg::coef_t c;
    set_point(0, 0);
    for (i = 0; i < LINE_LIMIT; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_line(pick_coef(), pick_coef(), pick_coef(), 1'b0);
      end else begin
        // lines tend to get nearer, so late positions win
        span = 1100 - i;
        c = nlp_pkg::coef_t'($urandom_range(0, span));
        if ($urandom_range(0, 1) == 1) c = -c;
        send_line(256, 0, c, 1'b0);
      end
    end
    send_line(pick_coef(), pick_coef(), pick_coef(), 1'b0);
    send_line(pick_coef(), pick_coef(), pick_coef(), 1'b1);
    wait_idle();
  endtask

  // Receiver holds off while single-line sets keep coming, so the block backs up
  task automatic test_output_backpressure();
    int k;
    set_point(pick_coef(), pick_coef());
    idling_on = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 30; k++) send_line(pick_coef(), pick_coef(), pick_coef(), 1'b1);
    idling_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_sets(input int total);
    int             sent;
    int             phase;
    int             phase_end;
    int             set_len;
    int             k;
    nlp_pkg::coef_t a;
    nlp_pkg::coef_t b;
    sent = 0;
    for (phase = 0; sent < total; phase++) begin
      case (phase)
        0:       set_point(-32768, -32768);
        1:       set_point(32767, 32767);
        2:       set_point(0, -32768);
        default: set_point(pick_coef(), pick_coef());
      endcase
      idling_on = (sent < total * 3 / 4) && (phase % 4 != 2);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < total) begin
        set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (k = 0; k < set_len; k++) begin
          a = pick_coef();
          b = pick_coef();
          if ($urandom_range(0, 9) == 0) begin
            a = '0;
            b = '0;
          end
          send_line(a, b, pick_coef(), k == set_len - 1);
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  // Result side: ready in random bursts, long hold on request
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      best_ch.ready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      best_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = $urandom_range(1, 12) - 1;
      best_ch.ready <= 1'b0;
    end else begin
      best_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_best
    nlp_pkg::best_t want;
    if (rst_ni && best_ch.valid && best_ch.ready) begin
      if (nearest_q.size() == 0) begin
        $error("unexpected result word: a %0d b %0d c %0d index %0d", best_ch.data.best_a,
               best_ch.data.best_b, best_ch.data.best_c, best_ch.data.best_index);
        fail_count++;
      end else begin
        want = nearest_q.pop_front();
        if (best_ch.data.best_a !== want.best_a) begin
          $error("best_a: expected %0d, got %0d", want.best_a, best_ch.data.best_a);
          fail_count++;
        end
        if (best_ch.data.best_b !== want.best_b) begin
          $error("best_b: expected %0d, got %0d", want.best_b, best_ch.data.best_b);
          fail_count++;
        end
        if (best_ch.data.best_c !== want.best_c) begin
          $error("best_c: expected %0d, got %0d", want.best_c, best_ch.data.best_c);
          fail_count++;
        end
        if (best_ch.data.best_index !== want.best_index) begin
          $error("best_index: expected %0d, got %0d", want.best_index, best_ch.data.best_index);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((line_ch.valid && line_ch.ready) || (best_ch.valid && best_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[nearest_line_to_point] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = nlp_pkg::CFG_POINT_X;
    cfg_data_i    = '0;
    line_ch.valid = 1'b0;
    line_ch.data  = '0;
    best_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_overlong_set();
    test_output_backpressure();
    test_random_sets(RANDOM_ITEMS);

    if (fail_count == 0) $display("[nearest_line_to_point] OK");
    else $display("[nearest_line_to_point] ERROR");
    $finish;
  end
endmodule
